FILE: rtl/epsc_pkg.sv
// Shared types and constants for the encoder PI speed controller.
// No dependencies.
package epsc_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PosW    = 32;
  localparam int unsigned TgtW    = 12;
  localparam int unsigned SpeedW  = 18;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned GainW   = 16;
  localparam int unsigned DutyW   = 10;
  localparam int unsigned IntegW  = 48;
  localparam int unsigned CfgIdxW = 2;

  // Speed numerator: 1e6 us/s * 60 s/min / 480 encoder pulses per rev
  localparam int unsigned QuoW     = 17;
  localparam logic [QuoW-1:0] SpeedNum = QuoW'(125000);

  // Serial step counts
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned MulESteps = TimeW;
  localparam int unsigned MulGSteps = GainW;
  localparam int unsigned CntW      = 5;

  // Product widths
  localparam int unsigned ProdEW = ErrW + TimeW;     // err * gap
  localparam int unsigned ProdIW = IntegW + GainW;   // integral * ki
  localparam int unsigned ProdPW = ErrW + GainW;     // err * kp
  localparam int unsigned IShift = 20;
  localparam int unsigned DShift = 8;
  localparam int unsigned SumW   = ProdIW - IShift + 1;
  localparam int unsigned DriveW = SumW - DShift;

  localparam logic [DutyW-1:0] DutyMax = DutyW'(1023);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKp = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKi = CfgIdxW'(1);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSpeed,
    StMulE,
    StInteg,
    StMulG,
    StDrive,
    StLoad
  } state_e;

endpackage

FILE: rtl/encoder_pi_speed_controller_unit.sv
// Encoder PI speed controller, top level.
// Depends on epsc_pkg.
//
// One input word is one rising A edge of a quadrature encoder: the B level,
// a microsecond timestamp and a target speed. The block steps the position
// count, estimates speed as +/-125000 / gap (gap = wrapped us since last
// edge, zero taken as 1), runs a PI law with Q8.8 gains (written over the
// config port, index 0 = kp, index 1 = ki) and returns one result word:
// direction, duty clamped to 1023, position and measured speed.
// Words are accepted only in the idle state, so the block takes no new word
// while one is in flight. The bit-serial datapath runs a 17-step restoring
// divider for the speed, a 32-step shift-add multiplier for error * gap, and
// a 16-step multiplier pass for both gains, plus four further steps (speed,
// integral, drive, load). A new word is accepted while the previous result
// still waits in the output register; the load step of that new word then
// stalls until the result register is free. Config writes are always
// accepted; a word in flight latches the gains at its integral step, so
// change gains between words.
module encoder_pi_speed_controller_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 phase_b_i,
  input  logic [epsc_pkg::TimeW-1:0]           now_us_i,
  input  logic signed [epsc_pkg::TgtW-1:0]     target_speed_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 drive_reverse_o,
  output logic [epsc_pkg::DutyW-1:0]           duty_o,
  output logic signed [epsc_pkg::PosW-1:0]     position_o,
  output logic signed [epsc_pkg::SpeedW-1:0]   measured_speed_o,
  // config writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [epsc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [epsc_pkg::GainW-1:0]           cfg_data_i
);

  localparam int unsigned TimeW  = epsc_pkg::TimeW;
  localparam int unsigned PosW   = epsc_pkg::PosW;
  localparam int unsigned QuoW   = epsc_pkg::QuoW;
  localparam int unsigned ErrW   = epsc_pkg::ErrW;
  localparam int unsigned GainW  = epsc_pkg::GainW;
  localparam int unsigned IntegW = epsc_pkg::IntegW;
  localparam int unsigned CntW   = epsc_pkg::CntW;
  localparam int unsigned ProdEW = epsc_pkg::ProdEW;
  localparam int unsigned ProdIW = epsc_pkg::ProdIW;
  localparam int unsigned ProdPW = epsc_pkg::ProdPW;
  localparam int unsigned SumW   = epsc_pkg::SumW;
  localparam int unsigned DriveW = epsc_pkg::DriveW;
  localparam int unsigned SatW   = ProdEW + 1;

  epsc_pkg::state_e state_q, state_d;

  // control and architectural state
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [GainW-1:0]         kp_q, ki_q;
  logic [epsc_pkg::PosW-1:0] edge_cnt_q;
  logic [TimeW-1:0]         last_time_q;
  logic signed [IntegW-1:0] integ_q;
  logic                     out_valid_q;

  // working registers
  logic                     up_q;
  logic signed [epsc_pkg::TgtW-1:0] target_q;
  logic [TimeW-1:0]         gap_q;       // divisor, then multiplier shift reg
  logic [QuoW-1:0]          num_q;       // dividend bits, MSB first
  logic [QuoW-1:0]          rem_q;
  logic [QuoW-1:0]          quo_q;
  logic signed [epsc_pkg::SpeedW-1:0] speed_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [ProdEW-1:0] acc_e_q;
  logic signed [ProdIW-1:0] acc_i_q;
  logic signed [ProdPW-1:0] acc_p_q;
  logic [GainW-1:0]         kp_sh_q, ki_sh_q;
  logic signed [DriveW-1:0] drive_q;

  // result register
  logic                     res_rev_q;
  logic [epsc_pkg::DutyW-1:0] res_duty_q;
  logic [epsc_pkg::PosW-1:0]  res_pos_q;
  logic signed [epsc_pkg::SpeedW-1:0] res_speed_q;

  // handshake terms
  logic in_fire, out_free, cfg_fire;
  logic div_last, mule_last, mulg_last;

  assign in_fire  = in_valid_i && (state_q == epsc_pkg::StIdle);
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_fire = cfg_valid_i;

  assign div_last  = (cnt_q == CntW'(epsc_pkg::DivSteps - 1));
  assign mule_last = (cnt_q == CntW'(epsc_pkg::MulESteps - 1));
  assign mulg_last = (cnt_q == CntW'(epsc_pkg::MulGSteps - 1));

  // ---------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epsc_pkg::StIdle:  if (in_valid_i) state_d = epsc_pkg::StDiv;
      epsc_pkg::StDiv:   if (div_last)   state_d = epsc_pkg::StSpeed;
      epsc_pkg::StSpeed: state_d = epsc_pkg::StMulE;
      epsc_pkg::StMulE:  if (mule_last)  state_d = epsc_pkg::StInteg;
      epsc_pkg::StInteg: state_d = epsc_pkg::StMulG;
      epsc_pkg::StMulG:  if (mulg_last)  state_d = epsc_pkg::StDrive;
      epsc_pkg::StDrive: state_d = epsc_pkg::StLoad;
      epsc_pkg::StLoad:  if (out_free)   state_d = epsc_pkg::StIdle;
      default:           state_d = epsc_pkg::StIdle;
    endcase
  end

  // Step counter: runs inside the serial states, cleared on each exit
  always_comb begin
    unique case (state_q)
      epsc_pkg::StDiv:  cnt_d = div_last  ? '0 : cnt_q + CntW'(1);
      epsc_pkg::StMulE: cnt_d = mule_last ? '0 : cnt_q + CntW'(1);
      epsc_pkg::StMulG: cnt_d = mulg_last ? '0 : cnt_q + CntW'(1);
      default:          cnt_d = '0;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ready_o  = (state_q == epsc_pkg::StIdle);
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
  end

  // ---------------------------------------------------------------------
  // Datapath terms
  logic [TimeW-1:0]  diff;
  logic [QuoW:0]     div_trial;
  logic              div_ge;
  logic [QuoW-1:0]   div_rem;
  logic signed [epsc_pkg::SpeedW-1:0] speed_c;
  logic signed [SatW-1:0] integ_sum;
  logic signed [IntegW-1:0] integ_sat;
  logic signed [SumW-1:0]   drive_sum;
  logic              drive_neg;
  logic [DriveW-1:0] drive_mag;
  logic [epsc_pkg::DutyW-1:0] duty_c;

  assign diff = now_us_i - last_time_q;

  // restoring division step: compare shifted remainder with the gap
  assign div_trial = {rem_q, num_q[QuoW-1]};
  assign div_ge    = ({{(TimeW-QuoW-1){1'b0}}, div_trial} >= gap_q);
  assign div_rem   = div_ge ? QuoW'(div_trial - gap_q[QuoW:0]) : div_trial[QuoW-1:0];

  assign speed_c = up_q ? $signed({1'b0, quo_q}) : -$signed({1'b0, quo_q});

  // integral update, saturated to the store width
  assign integ_sum = SatW'(integ_q) + SatW'(acc_e_q);
  always_comb begin
    if (integ_sum[SatW-1:IntegW-1] == '0 || integ_sum[SatW-1:IntegW-1] == '1) begin
      integ_sat = integ_sum[IntegW-1:0];
    end else if (integ_sum[SatW-1]) begin
      integ_sat = {1'b1, {(IntegW-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(IntegW-1){1'b1}}};
    end
  end

  // arithmetic shifts floor toward minus infinity
  assign drive_sum = SumW'(acc_p_q) + SumW'(acc_i_q >>> epsc_pkg::IShift);
  assign drive_neg = drive_q[DriveW-1];
  assign drive_mag = drive_neg ? DriveW'(-drive_q) : DriveW'(drive_q);
  assign duty_c    = (drive_mag > DriveW'(epsc_pkg::DutyMax)) ? epsc_pkg::DutyMax
                                                              : drive_mag[epsc_pkg::DutyW-1:0];

  // ---------------------------------------------------------------------
  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epsc_pkg::StIdle;
      cnt_q       <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      edge_cnt_q  <= '0;
      last_time_q <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          epsc_pkg::RegKp: kp_q <= cfg_data_i;
          epsc_pkg::RegKi: ki_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        edge_cnt_q  <= phase_b_i ? edge_cnt_q + PosW'(1) : edge_cnt_q - PosW'(1);
        last_time_q <= now_us_i;
      end
      if (state_q == epsc_pkg::StInteg) integ_q <= integ_sat;
      if (state_q == epsc_pkg::StLoad && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Serial datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      epsc_pkg::StIdle: begin
        up_q     <= phase_b_i;
        target_q <= target_speed_i;
        gap_q    <= (diff == '0) ? TimeW'(1) : diff;
        num_q    <= epsc_pkg::SpeedNum;
        rem_q    <= '0;
        quo_q    <= '0;
      end
      epsc_pkg::StDiv: begin
        rem_q <= div_rem;
        num_q <= {num_q[QuoW-2:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], div_ge};
      end
      epsc_pkg::StSpeed: begin
        speed_q <= speed_c;
        err_q   <= ErrW'(target_q) - speed_c;
        acc_e_q <= '0;
      end
      epsc_pkg::StMulE: begin
        // MSB-first shift-add over the gap bits
        acc_e_q <= (acc_e_q <<< 1) + (gap_q[TimeW-1] ? ProdEW'(err_q) : '0);
        gap_q   <= {gap_q[TimeW-2:0], 1'b0};
      end
      epsc_pkg::StInteg: begin
        kp_sh_q <= kp_q;
        ki_sh_q <= ki_q;
        acc_i_q <= '0;
        acc_p_q <= '0;
      end
      epsc_pkg::StMulG: begin
        // both gain products in the same pass, one gain bit per cycle
        acc_i_q <= (acc_i_q <<< 1) + (ki_sh_q[GainW-1] ? ProdIW'(integ_q) : '0);
        acc_p_q <= (acc_p_q <<< 1) + (kp_sh_q[GainW-1] ? ProdPW'(err_q) : '0);
        ki_sh_q <= {ki_sh_q[GainW-2:0], 1'b0};
        kp_sh_q <= {kp_sh_q[GainW-2:0], 1'b0};
      end
      epsc_pkg::StDrive: begin
        drive_q <= DriveW'(drive_sum >>> epsc_pkg::DShift);
      end
      epsc_pkg::StLoad: begin
        if (out_free) begin
          res_rev_q   <= drive_neg;
          res_duty_q  <= duty_c;
          res_pos_q   <= edge_cnt_q;
          res_speed_q <= speed_q;
        end
      end
      default: ;
    endcase
  end

  assign drive_reverse_o  = res_rev_q;
  assign duty_o           = res_duty_q;
  assign position_o       = res_pos_q;
  assign measured_speed_o = res_speed_q;

endmodule
